// File: design/gbfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPS binary frame parser package
// Shared types and constants: parse phases, frame status codes, framing
// bytes and the result item layout.
// ----------------------------------------------------------------------------
package gbfp_pkg;

    // Framing bytes
    localparam logic [7:0] SYNC_A = 8'hA0;
    localparam logic [7:0] SYNC_B = 8'hA1;
    localparam logic [7:0] TAIL_A = 8'h0D;
    localparam logic [7:0] TAIL_B = 8'h0A;

    // Reset value of the maximum payload length register
    localparam logic [15:0] MAX_LENGTH_RESET = 16'd200;

    // Parse phase
    typedef enum logic [2:0] {
        PH_HUNT1   = 3'd0,
        PH_HUNT2   = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CHECK   = 3'd5,
        PH_TAIL1   = 3'd6,
        PH_TAIL2   = 3'd7
    } phase_t;

    // Frame end status
    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_CHECKSUM = 2'd1,
        ST_TRAILER  = 2'd2,
        ST_TOO_LONG = 2'd3
    } status_t;

    // Result kind
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // One result item
    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        status_t     status;
        logic [15:0] frame_length;
    } result_t;

endpackage

// File: design/gbfp_frame_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPS binary frame parser state machine
// Holds the parse state and the length limit register, and works out the
// next state and the result item for each accepted byte combinationally.
// ----------------------------------------------------------------------------
module gbfp_frame_fsm #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_data,
    input  logic                 step,
    input  logic [7:0]           rx_byte,
    output logic                 res_valid,
    output gbfp_pkg::result_t    res
);

    localparam int CountWidth = LENGTH_BITS + 1;
    localparam logic [15:0] CountLimit = 16'((32'd1 << LENGTH_BITS) - 32'd1);

    gbfp_pkg::phase_t         phase_reg, phase_next;
    logic [15:0]              max_length_reg;
    logic [15:0]              ann_reg, ann_next;
    logic [LENGTH_BITS-1:0]   count_reg, count_next;
    logic [7:0]               xor_reg, xor_next;
    logic [7:0]               chk_reg, chk_next;
    logic                     tail_ok_reg, tail_ok_next;
    logic [CountWidth-1:0]    count_inc;
    logic [15:0]              len_new;

    assign count_inc = {1'b0, count_reg} + CountWidth'(1);
    assign len_new   = {ann_reg[15:8], rx_byte};

    // Next state and result for the byte on the input
    always_comb
    begin
        phase_next   = phase_reg;
        ann_next     = ann_reg;
        count_next   = count_reg;
        xor_next     = xor_reg;
        chk_next     = chk_reg;
        tail_ok_next = tail_ok_reg;
        res_valid    = 1'b0;
        res.kind         = gbfp_pkg::KIND_PAYLOAD;
        res.payload_byte = 8'd0;
        res.byte_index   = 16'd0;
        res.status       = gbfp_pkg::ST_GOOD;
        res.frame_length = ann_reg;

        case (phase_reg)
            gbfp_pkg::PH_HUNT2:
            begin
                if (rx_byte == gbfp_pkg::SYNC_B)
                    phase_next = gbfp_pkg::PH_LEN_HI;
                else if (rx_byte != gbfp_pkg::SYNC_A)
                    phase_next = gbfp_pkg::PH_HUNT1;
            end
            gbfp_pkg::PH_LEN_HI:
            begin
                ann_next   = {rx_byte, 8'd0};
                phase_next = gbfp_pkg::PH_LEN_LO;
            end
            gbfp_pkg::PH_LEN_LO:
            begin
                ann_next   = len_new;
                count_next = '0;
                xor_next   = 8'd0;
                res.frame_length = len_new;
                if (len_new > max_length_reg || len_new > CountLimit)
                begin
                    phase_next = gbfp_pkg::PH_HUNT1;
                    res_valid  = 1'b1;
                    res.kind   = gbfp_pkg::KIND_STATUS;
                    res.status = gbfp_pkg::ST_TOO_LONG;
                end
                else if (len_new == 16'd0)
                    phase_next = gbfp_pkg::PH_CHECK;
                else
                    phase_next = gbfp_pkg::PH_PAYLOAD;
            end
            gbfp_pkg::PH_PAYLOAD:
            begin
                res_valid        = 1'b1;
                res.payload_byte = rx_byte;
                res.byte_index   = 16'(count_reg);
                xor_next         = xor_reg ^ rx_byte;
                count_next       = count_inc[LENGTH_BITS-1:0];
                if (17'(count_inc) >= {1'b0, ann_reg})
                    phase_next = gbfp_pkg::PH_CHECK;
            end
            gbfp_pkg::PH_CHECK:
            begin
                chk_next   = rx_byte;
                phase_next = gbfp_pkg::PH_TAIL1;
            end
            gbfp_pkg::PH_TAIL1:
            begin
                tail_ok_next = (rx_byte == gbfp_pkg::TAIL_A);
                phase_next   = gbfp_pkg::PH_TAIL2;
            end
            gbfp_pkg::PH_TAIL2:
            begin
                res_valid  = 1'b1;
                res.kind   = gbfp_pkg::KIND_STATUS;
                phase_next = gbfp_pkg::PH_HUNT1;
                // a bad trailer wins over a checksum mismatch
                if (!tail_ok_reg || rx_byte != gbfp_pkg::TAIL_B)
                    res.status = gbfp_pkg::ST_TRAILER;
                else if (xor_reg != chk_reg)
                    res.status = gbfp_pkg::ST_CHECKSUM;
                else
                    res.status = gbfp_pkg::ST_GOOD;
            end
            default:
            begin
                phase_next = (rx_byte == gbfp_pkg::SYNC_A) ? gbfp_pkg::PH_HUNT2
                                                           : gbfp_pkg::PH_HUNT1;
            end
        endcase
    end

    // Parse state, advanced once per accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= gbfp_pkg::PH_HUNT1;
            ann_reg     <= 16'd0;
            count_reg   <= '0;
            xor_reg     <= 8'd0;
            chk_reg     <= 8'd0;
            tail_ok_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            ann_reg     <= ann_next;
            count_reg   <= count_next;
            xor_reg     <= xor_next;
            chk_reg     <= chk_next;
            tail_ok_reg <= tail_ok_next;
        end
    end

    // Length limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_length_reg <= gbfp_pkg::MAX_LENGTH_RESET;
        else if (cfg_we)
            max_length_reg <= cfg_data;
    end

endmodule

// File: design/gps_binary_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPS binary frame parser
// Frames binary GPS messages from a received byte stream and passes on
// payload bytes and one status item per frame.
// ----------------------------------------------------------------------------
// Usage:
//   Received bytes enter on the s_ side, one per item. Each payload byte
//   leaves on the m_ side with its index; the end of a frame, or a length
//   above cfg_data's limit, gives a status item (m_tuser high). Bytes
//   outside a frame give no item.
//   A result is registered in the result register, or first in the skid
//   register while the result register is full, before it shows on m_tdata.
//   One byte is taken every cycle while s_tready is high; the per-byte state update is combinational.
//   A result register and a skid register sit on the output, so a byte is
//   still taken while one result waits; when both are full, s_tready drops
//   until the receiver takes one.
//   Reset returns the parser to hunting for the start bytes, empties the
//   output and sets the length limit to 200. cfg_we writes the limit; the
//   user must use it only while the block is idle, as the block does not enforce this.
// ----------------------------------------------------------------------------
module gps_binary_frame_parser #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    // received bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] rx_byte
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,     // [7:0] payload_byte, [23:8] byte_index,
                                     // [25:24] frame_status, [41:26] frame_length
    output logic        m_tuser      // [0] result_kind
);

    logic                step;
    logic                res_valid;
    gbfp_pkg::result_t   res;
    gbfp_pkg::result_t   out_reg;
    gbfp_pkg::result_t   skid_reg;
    logic                out_valid_reg;
    logic                skid_valid_reg;
    logic                push;
    logic                pop;

    assign s_tready = !skid_valid_reg;
    assign step     = s_tvalid && s_tready;
    assign push     = step && res_valid;
    assign pop      = out_valid_reg && m_tready;

    gbfp_frame_fsm #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .step      (step),
        .rx_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output and skid valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    // Output and skid payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_reg <= skid_reg;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_reg <= res;
            else
                out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {6'd0, out_reg.frame_length, out_reg.status,
                       out_reg.byte_index, out_reg.payload_byte};

endmodule
